[hw/rtl/triangle_face_dedup_table_assert.svh]
// Assertion macros for the face dedup table.
`ifndef TRIANGLE_FACE_DEDUP_TABLE_ASSERT_SVH
`define TRIANGLE_FACE_DEDUP_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
`define TFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TFD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TFD_ASSERT(label, clk, rst, prop, msg)
`define TFD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[hw/rtl/tfd_pkg.sv]
`default_nettype none

package tfd_pkg;

   localparam int MAX_FACES    = 256;
   localparam int COORD_W      = 32;
   localparam int IDX_W        = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
   localparam int FACE_INDEX_W = 8;
   localparam int STATUS_W     = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_FOUND,
      STATUS_INSERTED,
      STATUS_FULL
   } status_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } corner_type;

   typedef corner_type [2:0] face_type;

   typedef struct packed {
      logic             valid;
      logic             done;
      status_type       status;
      logic [IDX_W-1:0] idx;
      face_type         face;
   } stage_type;

   // stored corner compared with query corner 0, 1, 2 for each ordering
   localparam logic [1:0] CORNER_ORDERS [6][3] = '{
      '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd0, 2'd2},
      '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd1, 2'd0}
   };

   function automatic logic face_match(input face_type stored, input face_type query);
      logic [2:0][2:0] eq;
      logic            hit;
      int              i;
      int              j;
      int              p;
      for (i = 0; i < 3; i++) begin
         for (j = 0; j < 3; j++) begin
            eq[i][j] = (stored[i] == query[j]);
         end
      end
      hit = 1'b0;
      for (p = 0; p < 6; p++) begin
         hit = hit | (eq[CORNER_ORDERS[p][0]][0] & eq[CORNER_ORDERS[p][1]][1]
                      & eq[CORNER_ORDERS[p][2]][2]);
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/tfd_if.sv]
`default_nettype none

interface tfd_req_if import tfd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] corner0_x;
   logic [COORD_W-1:0] corner0_y;
   logic [COORD_W-1:0] corner0_z;
   logic [COORD_W-1:0] corner1_x;
   logic [COORD_W-1:0] corner1_y;
   logic [COORD_W-1:0] corner1_z;
   logic [COORD_W-1:0] corner2_x;
   logic [COORD_W-1:0] corner2_y;
   logic [COORD_W-1:0] corner2_z;

   modport source (
      output valid, corner0_x, corner0_y, corner0_z, corner1_x, corner1_y, corner1_z,
             corner2_x, corner2_y, corner2_z,
      input  ready
   );
   modport sink (
      input  valid, corner0_x, corner0_y, corner0_z, corner1_x, corner1_y, corner1_z,
             corner2_x, corner2_y, corner2_z,
      output ready
   );
endinterface

interface tfd_rsp_if import tfd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [FACE_INDEX_W-1:0] face_index;
   logic [STATUS_W-1:0]     lookup_status;

   modport source (output valid, face_index, lookup_status, input ready);
   modport sink (input valid, face_index, lookup_status, output ready);
endinterface

`default_nettype wire

[hw/rtl/tfd_cell.sv]
`default_nettype none

`include "triangle_face_dedup_table_assert.svh"

module tfd_cell import tfd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             enable,
   input  wire logic [IDX_W-1:0] cell_idx,
   input  wire stage_type        stage_in,
   output stage_type             stage_out
);

   face_type  face_ff;
   logic      face_valid_ff;
   stage_type stage_ff;
   stage_type stage_in_next;
   logic      active;
   logic      hit;
   logic      capture;

   assign active  = stage_in.valid && !stage_in.done;
   assign hit     = face_match(face_ff, stage_in.face);
   assign capture = enable && active && !face_valid_ff;

   always_comb begin
      stage_in_next = stage_in;
      if (active) begin
         if (!face_valid_ff) begin
            stage_in_next.done   = 1'b1;
            stage_in_next.status = STATUS_INSERTED;
            stage_in_next.idx    = cell_idx;
         end else if (hit) begin
            stage_in_next.done   = 1'b1;
            stage_in_next.status = STATUS_FOUND;
            stage_in_next.idx    = cell_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         face_valid_ff  <= 1'b0;
         stage_ff.valid <= 1'b0;
      end else begin
         if (capture) begin
            face_valid_ff <= 1'b1;
         end
         if (enable) begin
            stage_ff <= stage_in_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         face_ff <= stage_in.face;
      end
   end

   assign stage_out = stage_ff;

   `TFD_ASSERT(a_face_kept, clock, reset, face_valid_ff |=> face_valid_ff, "stored face lost")
   `TFD_ASSERT(a_empty_cell_captures, clock, reset,
      capture |=> (face_valid_ff && stage_ff.done && stage_ff.status == STATUS_INSERTED),
      "empty cell did not capture item")
   `TFD_ASSERT(a_hit_index, clock, reset,
      (enable && active && face_valid_ff && hit) |=>
         (stage_ff.done && stage_ff.status == STATUS_FOUND && stage_ff.idx == cell_idx),
      "match reported with wrong index")

endmodule

`default_nettype wire

[hw/rtl/triangle_face_dedup_table.sv]
// Triangle face dedup table: a row of MAX_FACES cells, one stored face each.
// A query passes through the cell registers in order and then the rsp register;
// it walks the whole row even after a hit.
// Throughput: one item per cycle; the whole row stalls while rsp is held.
// Reset clears the per-cell valid bits and the pipeline; stored
// face data is not cleared and items are taken right after reset.
`default_nettype none

`include "triangle_face_dedup_table_assert.svh"

module triangle_face_dedup_table import tfd_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   tfd_req_if.sink  req,
   tfd_rsp_if.source rsp
);

   stage_type                stage [MAX_FACES+1];
   stage_type                tail;
   logic                     enable;
   logic                     rsp_valid_ff;
   logic [FACE_INDEX_W-1:0]  face_index_ff;
   status_type               status_ff;

   assign enable    = !rsp_valid_ff || rsp.ready;
   assign req.ready = enable;

   always_comb begin
      stage[0].valid  = req.valid;
      stage[0].done   = 1'b0;
      stage[0].status = STATUS_FULL;
      stage[0].idx    = '0;
      stage[0].face[0] = '{x: req.corner0_x, y: req.corner0_y, z: req.corner0_z};
      stage[0].face[1] = '{x: req.corner1_x, y: req.corner1_y, z: req.corner1_z};
      stage[0].face[2] = '{x: req.corner2_x, y: req.corner2_y, z: req.corner2_z};
   end

   for (genvar j = 0; j < MAX_FACES; j++) begin : g_cell
      tfd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .cell_idx  (IDX_W'(j)),
         .stage_in  (stage[j]),
         .stage_out (stage[j+1])
      );
   end

   assign tail = stage[MAX_FACES];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && tail.valid) begin
         if (tail.done) begin
            status_ff     <= tail.status;
            face_index_ff <= FACE_INDEX_W'(tail.idx);
         end else begin
            status_ff     <= STATUS_FULL;
            face_index_ff <= '0;
         end
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.face_index    = face_index_ff;
   assign rsp.lookup_status = status_ff;

   `TFD_ASSERT(a_full_index_zero, clock, reset,
      (rsp_valid_ff && status_ff == STATUS_FULL) |-> (face_index_ff == '0),
      "full status with nonzero index")
   `TFD_ASSERT(a_unplaced_is_full, clock, reset,
      (enable && tail.valid && !tail.done) |=> (rsp_valid_ff && status_ff == STATUS_FULL),
      "unplaced item not reported full")
   `TFD_ASSERT(a_row_frozen, clock, reset,
      !enable |=> $stable(tail),
      "cell row moved while rsp held")

endmodule

`default_nettype wire

[sim/triangle_face_dedup_table_tb.sv]
`default_nettype none

module triangle_face_dedup_table_tb import tfd_pkg::*; ();

   localparam int RANDOM_ITEMS   = 600;
   localparam int FILL_PHASE     = 350;
   localparam int RESET_CYCLES   = 10;
   localparam int DRAIN_CYCLES   = MAX_FACES + 50;
   localparam int WATCHDOG_LIMIT = 8 * (MAX_FACES + 8);
   localparam int REQ_SIDE       = 0;
   localparam int RSP_SIDE       = 1;

   localparam logic [COORD_W-1:0] SPECIAL_WORDS [8] = '{
      32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
      32'h7fc0_0000, 32'hffff_ffff, 32'h3f80_0000, 32'hbf80_0000
   };

   typedef struct packed {
      logic [FACE_INDEX_W-1:0] face_idx;
      status_type              status;
   } lookup_result_type;

   logic clock;
   logic reset;

   tfd_req_if req_if ();
   tfd_rsp_if rsp_if ();

   triangle_face_dedup_table i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   face_type          triangle_queue [$];
   face_type          sent_faces [$];
   corner_type        corner_pool [$];
   lookup_result_type expected_lookups [$];

   face_type stored_faces [MAX_FACES];
   int       face_count = 0;

   face_type drive_face;
   int       total_items = 0;
   int       accepted_items = 0;
   int       error_count = 0;
   int       req_gap = 0;
   int       rsp_hold = 0;
   int       idle_cycles = 0;
   bit       idle_on [2] = '{1'b0, 1'b0};
   int       mode_left [2] = '{0, 0};

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // alternates stretches with random stalls and stretches running flat out
   function automatic int draw_gap(input int side);
      if (mode_left[side] == 0) begin
         idle_on[side]   = ($urandom_range(0, 3) != 0);
         mode_left[side] = $urandom_range(10, 40);
      end
      mode_left[side]--;
      return idle_on[side] ? $urandom_range(0, 6) : 0;
   endfunction

   function automatic bit same_triangle(input face_type stored, input face_type query);
      int a;
      int b;
      int c;
      for (a = 0; a < 3; a++) begin
         for (b = 0; b < 3; b++) begin
            for (c = 0; c < 3; c++) begin
               if (a != b && b != c && a != c && stored[a] == query[0]
                   && stored[b] == query[1] && stored[c] == query[2]) begin
                  return 1'b1;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic lookup_result_type lookup_face(input face_type query);
      lookup_result_type r;
      int                i;
      for (i = 0; i < face_count; i++) begin
         if (same_triangle(stored_faces[i], query)) begin
            r.face_idx = FACE_INDEX_W'(i);
            r.status   = STATUS_FOUND;
            return r;
         end
      end
      if (face_count >= MAX_FACES) begin
         r.face_idx = '0;
         r.status   = STATUS_FULL;
      end else begin
         stored_faces[face_count] = query;
         r.face_idx = FACE_INDEX_W'(face_count);
         r.status   = STATUS_INSERTED;
         face_count++;
      end
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0: begin
            return SPECIAL_WORDS[$urandom_range(0, 7)];
         end
         1: begin
            return COORD_W'($urandom_range(0, 3));
         end
         default: begin
            return $urandom();
         end
      endcase
   endfunction

   // shared vertices, as in a real mesh, give many near matches
   function automatic corner_type rand_corner();
      corner_type c;
      if (corner_pool.size() > 0 && $urandom_range(0, 2) == 0) begin
         return corner_pool[$urandom_range(0, corner_pool.size() - 1)];
      end
      c.x = rand_word();
      c.y = rand_word();
      c.z = rand_word();
      corner_pool.push_back(c);
      return c;
   endfunction

   function automatic face_type make_face(input corner_type c0, input corner_type c1,
                                          input corner_type c2);
      face_type f;
      f[0] = c0;
      f[1] = c1;
      f[2] = c2;
      return f;
   endfunction

   function automatic face_type shuffled(input face_type f);
      corner_type t;
      int         j;
      j    = $urandom_range(0, 2);
      t    = f[0];
      f[0] = f[j];
      f[j] = t;
      j    = $urandom_range(1, 2);
      t    = f[1];
      f[1] = f[j];
      f[j] = t;
      return f;
   endfunction

   task automatic push_face(input face_type f);
      triangle_queue.push_back(f);
      sent_faces.push_back(f);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap      <= draw_gap(REQ_SIDE);
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_lookups.push_back(lookup_face(drive_face));
            accepted_items++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_gap      <= req_gap - 1;
               req_if.valid <= 1'b0;
            end else if (triangle_queue.size() > 0) begin
               drive_face = triangle_queue.pop_front();
               req_if.valid     <= 1'b1;
               req_if.corner0_x <= drive_face[0].x;
               req_if.corner0_y <= drive_face[0].y;
               req_if.corner0_z <= drive_face[0].z;
               req_if.corner1_x <= drive_face[1].x;
               req_if.corner1_y <= drive_face[1].y;
               req_if.corner1_z <= drive_face[1].z;
               req_if.corner2_x <= drive_face[2].x;
               req_if.corner2_y <= drive_face[2].y;
               req_if.corner2_z <= drive_face[2].z;
               req_gap          <= draw_gap(REQ_SIDE);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      int                next_hold;
      lookup_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold     <= 0;
      end else begin
         next_hold = rsp_hold;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_lookups.size() == 0) begin
               report_mismatch($sformatf("unexpected item: face_index %0d lookup_status %0d",
                                         rsp_if.face_index, rsp_if.lookup_status));
            end else begin
               want = expected_lookups.pop_front();
               if (rsp_if.face_index !== want.face_idx) begin
                  report_mismatch($sformatf("face_index %0d, expected %0d",
                                            rsp_if.face_index, want.face_idx));
               end
               if (rsp_if.lookup_status !== want.status) begin
                  report_mismatch($sformatf("lookup_status %0d, expected %s",
                                            rsp_if.lookup_status, want.status.name()));
               end
            end
            next_hold = draw_gap(RSP_SIDE);
         end else if (next_hold > 0) begin
            next_hold--;
         end
         rsp_hold     <= next_hold;
         rsp_if.ready <= (next_hold == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TIMEOUT: no item moved for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_lookups.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      corner_type  c_one;
      corner_type  c_two;
      corner_type  c_three;
      corner_type  c_zero;
      corner_type  c_ones;
      corner_type  c_negz;
      corner_type  c_nan;
      corner_type  c_nan2;
      corner_type  c_tweak;
      corner_type  c_swap;
      face_type    f;
      logic [95:0] flip;
      int          k;
      int          pick;
      int          new_pct;
      int          c;

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.corner0_x = '0;
      req_if.corner0_y = '0;
      req_if.corner0_z = '0;
      req_if.corner1_x = '0;
      req_if.corner1_y = '0;
      req_if.corner1_z = '0;
      req_if.corner2_x = '0;
      req_if.corner2_y = '0;
      req_if.corner2_z = '0;
      rsp_if.ready     = 1'b0;

      c_one   = '{32'h3f80_0000, 32'h4000_0000, 32'h4040_0000};
      c_two   = '{32'hbf80_0000, 32'h0000_0000, 32'h7f80_0000};
      c_three = '{32'h0000_0001, 32'h8000_0000, 32'hff80_0000};
      c_zero  = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
      c_ones  = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
      c_negz  = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      c_nan   = '{32'h7fc0_0000, 32'h7fc0_0001, 32'hffc0_0000};
      c_nan2  = '{32'h7f80_0001, 32'hffff_fffe, 32'h7fc0_0000};
      c_tweak = '{c_three.x, c_three.y, c_three.z ^ 32'h0000_0001};
      c_swap  = '{c_one.y, c_one.x, c_one.z};

      // all six corner orderings of one face
      push_face(make_face(c_one, c_two, c_three));
      push_face(make_face(c_one, c_three, c_two));
      push_face(make_face(c_two, c_one, c_three));
      push_face(make_face(c_two, c_three, c_one));
      push_face(make_face(c_three, c_one, c_two));
      push_face(make_face(c_three, c_two, c_one));
      push_face(make_face(c_one, c_two, c_three));
      // extremes; +0 and -0 are different patterns
      push_face(make_face(c_zero, c_zero, c_zero));
      push_face(make_face(c_ones, c_ones, c_ones));
      push_face(make_face(c_negz, c_negz, c_negz));
      push_face(make_face(c_zero, c_negz, c_zero));
      push_face(make_face(c_negz, c_zero, c_zero));
      // NaN patterns equal themselves
      push_face(make_face(c_nan, c_one, c_nan2));
      push_face(make_face(c_nan2, c_nan, c_one));
      // coincident corners
      push_face(make_face(c_one, c_one, c_two));
      push_face(make_face(c_one, c_two, c_two));
      push_face(make_face(c_two, c_one, c_one));
      // near misses
      push_face(make_face(c_one, c_two, c_tweak));
      push_face(make_face(c_swap, c_two, c_three));
      push_face(make_face(c_ones, c_zero, c_ones));

      // first fill the table for FILL_PHASE items, then mostly repeats
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         pick    = $urandom_range(0, 99);
         new_pct = (k < FILL_PHASE) ? 60 : 20;
         if (pick < new_pct) begin
            f = make_face(rand_corner(), rand_corner(), rand_corner());
         end else begin
            f = sent_faces[$urandom_range(0, sent_faces.size() - 1)];
            if (pick >= 90) begin
               c = $urandom_range(0, 2);
               if ($urandom_range(0, 1) == 1) begin
                  flip = 96'd1 << $urandom_range(0, 95);
                  f[c] = corner_type'(f[c] ^ flip);
               end else begin
                  f[c] = rand_corner();
               end
            end
            f = shuffled(f);
         end
         push_face(f);
      end
      total_items = triangle_queue.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (accepted_items < total_items || expected_lookups.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
